[rtl/lpfd_pkg.sv]
// Package for the length-prefixed frame deframer.
// Holds the status codes, the frame state and result structs, and the header constants.
// No dependencies.
`default_nettype none

package lpfd_pkg;

  localparam int unsigned HdrLen = 4;
  localparam logic [31:0] LenUnknown = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    StHeader  = 3'd0,
    StPayload = 3'd1,
    StDone    = 3'd2,
    StBadLen  = 3'd3,
    StRestart = 3'd4
  } status_e;

  typedef struct packed {
    logic [23:0] header_bytes;
    logic [31:0] received_count;
    logic [31:0] total_length;
  } frame_state_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  payload_byte;
    logic [31:0] payload_index;
    logic        frame_done;
    logic [31:0] frame_length;
  } result_t;

endpackage

`default_nettype wire

[rtl/lpfd_if.sv]
// Valid/ready channel interfaces for the frame deframer: byte input and result output.
// Depends on lpfd_pkg for the status type.
`default_nettype none

interface lpfd_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;

  modport source (output valid, func, data_byte, input ready);
  modport sink   (input valid, func, data_byte, output ready);
endinterface

interface lpfd_out_if;
  logic               valid;
  logic               ready;
  lpfd_pkg::status_e  status;
  logic [7:0]         payload_byte;
  logic [31:0]        payload_index;
  logic               frame_done;
  logic [31:0]        frame_length;

  modport source (output valid, status, payload_byte, payload_index, frame_done, frame_length,
                  input ready);
  modport sink   (input valid, status, payload_byte, payload_index, frame_done, frame_length,
                  output ready);
endinterface

`default_nettype wire

[rtl/lpfd_step.sv]
// Next-state and result logic of the deframer for one accepted word.
// Depends on lpfd_pkg for the state and result structs.
`default_nettype none

module lpfd_step (
  input  lpfd_pkg::frame_state_t state_i,
  input  logic                   func_i,
  input  logic [7:0]             data_byte_i,
  output lpfd_pkg::frame_state_t state_o,
  output lpfd_pkg::result_t      result_o
);

  logic [31:0] len_full;
  logic [31:0] count_inc;
  logic        in_header;

  assign len_full  = {data_byte_i, state_i.header_bytes};
  assign count_inc = state_i.received_count + 32'd1;
  assign in_header = state_i.received_count < 32'(lpfd_pkg::HdrLen);

  always_comb begin
    state_o                = state_i;
    result_o.status        = lpfd_pkg::StHeader;
    result_o.payload_byte  = 8'd0;
    result_o.payload_index = 32'd0;
    result_o.frame_done    = 1'b0;
    result_o.frame_length  = 32'd0;

    priority if (func_i) begin
      state_o.header_bytes   = 24'd0;
      state_o.received_count = 32'd0;
      state_o.total_length   = lpfd_pkg::LenUnknown;
      result_o.status        = lpfd_pkg::StRestart;
    end else if (in_header) begin
      // The count is below four here, so its low two bits pick the byte lane.
      unique case (state_i.received_count[1:0])
        2'd0: state_o.header_bytes[7:0]   = data_byte_i;
        2'd1: state_o.header_bytes[15:8]  = data_byte_i;
        2'd2: state_o.header_bytes[23:16] = data_byte_i;
        default: begin
          state_o.total_length  = len_full;
          result_o.frame_length = len_full;
          result_o.frame_done   = (len_full == 32'(lpfd_pkg::HdrLen));
        end
      endcase
      state_o.received_count = count_inc;
    end else if (state_i.total_length < 32'(lpfd_pkg::HdrLen)) begin
      result_o.status       = lpfd_pkg::StBadLen;
      result_o.frame_length = state_i.total_length;
    end else if (state_i.received_count >= state_i.total_length) begin
      result_o.status       = lpfd_pkg::StDone;
      result_o.frame_length = state_i.total_length;
    end else begin
      state_o.received_count = count_inc;
      result_o.status        = lpfd_pkg::StPayload;
      result_o.payload_byte  = data_byte_i;
      result_o.payload_index = state_i.received_count - 32'(lpfd_pkg::HdrLen);
      result_o.frame_done    = (count_inc == state_i.total_length);
      result_o.frame_length  = state_i.total_length;
    end
  end

endmodule

`default_nettype wire

[rtl/length_prefixed_frame_deframer_top.sv]
// Top level of the length-prefixed frame deframer (32-bit little-endian length).
// Depends on lpfd_pkg, lpfd_in_if, lpfd_out_if and lpfd_step.
//
//   channel  | dir | payload                                                    | accept
//   in_i     | in  | func, data_byte                                            | valid & ready
//   out_o    | out | status, payload_byte, payload_index, frame_done, frame_len | valid & ready
//
// Each accepted word gives exactly one result, shown by the output register in the next cycle.
// A word can be accepted in every cycle unless a full output register is stalled; the frame
// state and result register update at the same edge, so the next word sees the new state.
// The input is ready whenever the output register is empty or being drained this cycle.
// Reset clears the frame state to its initial values and empties the output register.
`default_nettype none

module length_prefixed_frame_deframer_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  lpfd_in_if.sink          in_i,
  lpfd_out_if.source       out_o
);

  lpfd_pkg::frame_state_t state_q, state_d;
  lpfd_pkg::result_t      result_q, result_d;
  logic                   out_valid_q;
  logic                   in_accept;

  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign in_accept  = in_i.valid & in_i.ready;

  lpfd_step u_step (
    .state_i     (state_q),
    .func_i      (in_i.func),
    .data_byte_i (in_i.data_byte),
    .state_o     (state_d),
    .result_o    (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.header_bytes   <= 24'd0;
      state_q.received_count <= 32'd0;
      state_q.total_length   <= lpfd_pkg::LenUnknown;
      out_valid_q            <= 1'b0;
    end else begin
      if (in_accept) begin
        state_q <= state_d;
      end
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = result_q.status;
  assign out_o.payload_byte  = result_q.payload_byte;
  assign out_o.payload_index = result_q.payload_index;
  assign out_o.frame_done    = result_q.frame_done;
  assign out_o.frame_length  = result_q.frame_length;

`ifndef SYNTHESIS
  // A restart word always comes back as a restarted result at the next edge.
  a_restart_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_i.func) |=> (out_o.valid && out_o.status == lpfd_pkg::StRestart))
    else $error("restart word did not produce a restarted result");

  // Once the header is in and the length is sane, the count never runs past the length.
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.received_count >= 32'(lpfd_pkg::HdrLen) &&
     state_q.total_length >= 32'(lpfd_pkg::HdrLen))
    |-> (state_q.received_count <= state_q.total_length))
    else $error("received count passed the frame length");

  // A payload byte always lies inside the declared payload.
  a_index_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == lpfd_pkg::StPayload)
    |-> (out_o.frame_length > 32'(lpfd_pkg::HdrLen) &&
         out_o.payload_index <= out_o.frame_length - 32'(lpfd_pkg::HdrLen + 1)))
    else $error("payload index outside the frame");

  // Only a taken header or payload byte can complete a frame.
  a_done_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.frame_done)
    |-> (out_o.status == lpfd_pkg::StHeader || out_o.status == lpfd_pkg::StPayload))
    else $error("frame completion flagged on a refused or restart result");
`endif

endmodule

`default_nettype wire
